FILE: hdl/h4d_pkg.sv
`timescale 1ns / 1ps

package h4d_pkg;

  // header geometry of the two packet kinds
  localparam int unsigned ACL_HEADER_BYTES   = 4;
  localparam int unsigned EVENT_HEADER_BYTES = 2;
  localparam int unsigned ACL_LEN_LOW_POS    = 3;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] len_t;
  typedef logic [2:0]  status_t;
  typedef logic [1:0]  reg_index_t;
  typedef logic [2:0]  hdr_count_t;

  // result status codes
  localparam status_t ST_TYPE     = 3'd0;
  localparam status_t ST_HEADER   = 3'd1;
  localparam status_t ST_PAYLOAD  = 3'd2;
  localparam status_t ST_BAD_TYPE = 3'd3;
  localparam status_t ST_OVERSIZE = 3'd4;

  // configuration register indexes
  localparam reg_index_t REG_ACL_TYPE  = 2'd0;
  localparam reg_index_t REG_EVT_TYPE  = 2'd1;
  localparam reg_index_t REG_MAX_LEN   = 2'd2;

  // register reset values
  localparam byte_t ACL_TYPE_RESET = 8'd2;
  localparam byte_t EVT_TYPE_RESET = 8'd4;
  localparam len_t  MAX_LEN_RESET  = 16'd1024;

endpackage

FILE: hdl/h4d_if.sv
`timescale 1ns / 1ps

// received UART byte stream
interface h4d_rx_if;
  logic           valid;
  logic           ready;
  h4d_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// framed result stream
interface h4d_res_if;
  logic             valid;
  logic             ready;
  h4d_pkg::byte_t   data_byte;
  h4d_pkg::status_t status;
  logic             is_acl;
  logic             last;

  modport source (output valid, output data_byte, output status, output is_acl,
                  output last, input ready);
  modport sink   (input valid, input data_byte, input status, input is_acl,
                  input last, output ready);
endinterface

// configuration register writes
interface h4d_cfg_if;
  logic                 valid;
  logic                 ready;
  h4d_pkg::reg_index_t  index;
  h4d_pkg::len_t        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/h4_uart_receive_deframer_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                            | Request accepted
// rx      | in  | rx_byte[7:0]                       | rx.valid & rx.ready
// res     | out | data_byte, status[2:0], is_acl, last | res.valid & res.ready
// cfg     | in  | index[1:0], data[15:0]             | cfg.valid & cfg.ready
//
// One byte per clock while the sink keeps up: each accepted byte gives one result in the next cycle.
// That result is held in the single result register after the framing logic.
// rx.ready is high whenever the result register is empty or being drained,
// so a stalled sink holds one result and backs up the byte stream.
// rst (synchronous) returns framing to waiting for a type byte and loads
// register defaults: ACL type 2, event type 4, max payload 1024.
// cfg is always ready; writes to index 3 are ignored.

module h4_uart_receive_deframer_top (
  input  logic        clk,
  input  logic        rst,
  h4d_rx_if.sink      rx,
  h4d_res_if.source   res,
  h4d_cfg_if.sink     cfg
);
  import h4d_pkg::*;

  // framing phase codes
  localparam logic [1:0] PH_TYPE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_UNUSED  = 2'd3;

  // configuration registers
  byte_t acl_type_code;
  byte_t event_type_code;
  len_t  max_payload_len;

  // framing state
  logic [1:0] phase, phase_next;
  hdr_count_t header_count, header_count_next;
  len_t       remaining, remaining_next;
  logic       packet_is_acl, packet_is_acl_next;
  byte_t      length_low, length_low_next;

  // result computed for the byte at the input
  status_t status_next;
  logic    is_acl_next;
  logic    last_next;

  logic       rx_take;
  hdr_count_t hc_inc;
  hdr_count_t hdr_total;
  len_t       pkt_len;
  len_t       rem_dec;

  // result register frees when empty or when the sink takes it
  assign rx.ready = ~res.valid | res.ready;
  assign rx_take  = rx.valid & rx.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acl_type_code   <= ACL_TYPE_RESET;
      event_type_code <= EVT_TYPE_RESET;
      max_payload_len <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ACL_TYPE: acl_type_code   <= cfg.data[7:0];
        REG_EVT_TYPE: event_type_code <= cfg.data[7:0];
        REG_MAX_LEN:  max_payload_len <= cfg.data;
        default: ;
      endcase
    end
  end

  assign hc_inc    = header_count + 3'd1;
  assign hdr_total = packet_is_acl ? hdr_count_t'(ACL_HEADER_BYTES)
                                   : hdr_count_t'(EVENT_HEADER_BYTES);
  assign pkt_len   = packet_is_acl ? {rx.rx_byte, length_low} : {8'd0, rx.rx_byte};
  assign rem_dec   = remaining - 16'd1;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    remaining_next     = remaining;
    packet_is_acl_next = packet_is_acl;
    length_low_next    = length_low;
    status_next        = ST_BAD_TYPE;
    is_acl_next        = packet_is_acl;
    last_next          = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        header_count_next = hc_inc;
        if (packet_is_acl && hc_inc == hdr_count_t'(ACL_LEN_LOW_POS)) begin
          length_low_next = rx.rx_byte;
        end
        status_next = ST_HEADER;
        if (hc_inc >= hdr_total) begin
          // last header byte: length is complete
          header_count_next = '0;
          if (pkt_len > max_payload_len) begin
            phase_next     = PH_TYPE;
            remaining_next = '0;
            status_next    = ST_OVERSIZE;
          end else if (pkt_len == '0) begin
            phase_next     = PH_TYPE;
            remaining_next = '0;
            last_next      = 1'b1;
          end else begin
            phase_next     = PH_PAYLOAD;
            remaining_next = pkt_len;
          end
        end
      end
      PH_PAYLOAD: begin
        remaining_next = rem_dec;
        status_next    = ST_PAYLOAD;
        if (rem_dec == '0) begin
          phase_next = PH_TYPE;
          last_next  = 1'b1;
        end
      end
      default: begin
        // waiting for a type byte; ACL code wins when both match
        phase_next        = PH_TYPE;
        header_count_next = '0;
        remaining_next    = '0;
        is_acl_next       = 1'b0;
        if (rx.rx_byte == acl_type_code) begin
          packet_is_acl_next = 1'b1;
          is_acl_next        = 1'b1;
          phase_next         = PH_HEADER;
          status_next        = ST_TYPE;
        end else if (rx.rx_byte == event_type_code) begin
          packet_is_acl_next = 1'b0;
          phase_next         = PH_HEADER;
          status_next        = ST_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TYPE;
      header_count  <= '0;
      remaining     <= '0;
      packet_is_acl <= 1'b0;
      length_low    <= '0;
      res.valid     <= 1'b0;
    end else begin
      if (rx_take) begin
        phase         <= phase_next;
        header_count  <= header_count_next;
        remaining     <= remaining_next;
        packet_is_acl <= packet_is_acl_next;
        length_low    <= length_low_next;
        res.valid     <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (rx_take) begin
      res.data_byte <= rx.rx_byte;
      res.status    <= status_next;
      res.is_acl    <= is_acl_next;
      res.last      <= last_next;
    end
  end

`ifndef SYNTHESIS
  a_phase_used: assert property (@(posedge clk) disable iff (rst)
    phase != PH_UNUSED)
    else $error("framing phase took the unused code");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> remaining != '0)
    else $error("payload phase with nothing remaining");

  a_hdr_bound: assert property (@(posedge clk) disable iff (rst)
    header_count < hdr_count_t'(ACL_HEADER_BYTES))
    else $error("header count ran past the ACL header");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    rx_take && last_next |=> phase == PH_TYPE && res.valid && res.last)
    else $error("packet end did not return to type wait");

  a_bad_type_stays: assert property (@(posedge clk) disable iff (rst)
    rx_take && status_next == ST_BAD_TYPE |=> phase == PH_TYPE)
    else $error("dropped type byte left the type wait");
`endif

endmodule
